### rtl/core/dpsg_pkg.sv
// Shared codes, constants and result type for the dual PSG port decoder.
// No dependencies; used by the top level and its checker.
`default_nettype none

package dpsg_pkg;

	localparam logic       OP_WRITE = 1'b0;
	localparam logic       OP_READ  = 1'b1;

	localparam logic [1:0] PORT_ADDR_ONE = 2'd0;
	localparam logic [1:0] PORT_ADDR_TWO = 2'd1;
	localparam logic [1:0] PORT_DATA_ONE = 2'd2;
	localparam logic [1:0] PORT_DATA_TWO = 2'd3;

	localparam logic [1:0] CFG_PAD_MERGE    = 2'd0;
	localparam logic [1:0] CFG_RAPID_ENABLE = 2'd1;
	localparam logic [1:0] CFG_SWAP_BUTTONS = 2'd2;

	localparam logic [1:0] KEY_PAD_ONE = 2'd1;
	localparam logic [1:0] KEY_PAD_TWO = 2'd2;

	localparam logic [1:0] CHIP_ONE   = 2'd0;
	localparam logic [1:0] CHIP_TWO   = 2'd1;
	localparam logic [1:0] CHIP_THREE = 2'd2;

	localparam logic [7:0] REG_JOY    = 8'h0e;
	localparam logic [7:0] REG_PORT_B = 8'h0f;
	localparam logic [7:0] REG_LIMIT  = 8'h10;

	localparam logic [7:0] BTN_MASK     = 8'h30;
	localparam logic [7:0] BTN_KEEP     = ~8'h30;
	localparam logic [7:0] SEL_MASK     = 8'hc2;
	localparam logic [7:0] SEL_LATCH    = 8'h42;
	localparam logic [7:0] SEL_WRITE    = 8'h40;
	localparam logic [7:0] TOGGLE_BYTE  = 8'hf0;
	localparam logic [7:0] BTN_LOW      = 8'h10;
	localparam logic [7:0] RHYTHM_MASK  = 8'h0f;
	localparam logic [7:0] IDLE_BYTE    = 8'hff;

	localparam int SHADOW_DEPTH = 32;
	localparam int SHADOW_AW    = $clog2(SHADOW_DEPTH);

	typedef struct packed {
		logic [7:0] rdata;
		logic       psg_write;
		logic [1:0] psg_chip;
		logic [3:0] psg_addr;
		logic [7:0] psg_data;
		logic [3:0] rhythm_trigger;
	} result_t;

endpackage

`default_nettype wire

### rtl/core/dual_psg_port_decoder_with_joystick.sv
// Top level: bus front end of a three-PSG board with joystick read path.
// Depends on dpsg_pkg.
//
// channel | dir | handshake            | payload
// in      | in  | in_valid / in_ready  | op, port, wdata, pad_status, key_pad_status
// out     | out | out_valid/ out_ready | rdata, psg_write, psg_chip, psg_addr, psg_data,
//         |     |                      | rhythm_trigger
// cfg     | in  | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// One request per cycle unless the result stalls; input register, then result
// register. Latches, shadow registers and rapid phase update as a request leaves
// the input register. Reset clears all state but the result payload, shadow too;
// no clearing pass. A stall holds the result register; an empty input register
// takes one more request, then in_ready drops. cfg_ready is always high.
`default_nettype none

module dual_psg_port_decoder_with_joystick (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       op,
	input  wire logic [1:0] port,
	input  wire logic [7:0] wdata,
	input  wire logic [7:0] pad_status,
	input  wire logic [7:0] key_pad_status,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      rdata,
	output logic            psg_write,
	output logic [1:0]      psg_chip,
	output logic [3:0]      psg_addr,
	output logic [7:0]      psg_data,
	output logic [3:0]      rhythm_trigger,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	logic [1:0] pad_merge_q;
	logic       rapid_enable_q;
	logic       swap_buttons_q;

	logic [7:0] addr_one_q, addr_two_q, addr_three_q;
	logic [7:0] shadow_q [dpsg_pkg::SHADOW_DEPTH];
	logic       rapid_phase_q;

	logic       v_s1;
	logic       op_s1;
	logic [1:0] port_s1;
	logic [7:0] wdata_s1, pad_s1, key_s1;

	logic              out_v_q;
	dpsg_pkg::result_t res_q;

	logic adv;

	assign cfg_ready = 1'b1;
	assign adv       = v_s1 && (!out_v_q || out_ready);
	assign in_ready  = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_merge_q    <= '0;
			rapid_enable_q <= 1'b0;
			swap_buttons_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				dpsg_pkg::CFG_PAD_MERGE:    pad_merge_q    <= cfg_data[1:0];
				dpsg_pkg::CFG_RAPID_ENABLE: rapid_enable_q <= cfg_data[0];
				dpsg_pkg::CFG_SWAP_BUTTONS: swap_buttons_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1    <= dpsg_pkg::OP_WRITE;
			port_s1  <= dpsg_pkg::PORT_ADDR_ONE;
			wdata_s1 <= '0;
			pad_s1   <= '0;
			key_s1   <= '0;
		end else if (in_valid && in_ready) begin
			op_s1    <= op;
			port_s1  <= port;
			wdata_s1 <= wdata;
			pad_s1   <= pad_status;
			key_s1   <= key_pad_status;
		end
	end

	// decode of the request in the input register
	logic                          two;
	logic [7:0]                    raddr;
	logic [7:0]                    rd_shadow;
	logic [7:0]                    tog, joy_v, joy_m, joy_out;
	logic                          joy_rd;
	logic [7:0]                    old_b, src_b, sel;
	logic                          fall;
	dpsg_pkg::result_t             res_d;
	logic                          sh_we;
	logic [dpsg_pkg::SHADOW_AW-1:0] sh_idx;
	logic                          a1_we, a2_we, a3_we;

	assign two       = (port_s1 == dpsg_pkg::PORT_DATA_TWO);
	assign raddr     = two ? addr_two_q : addr_one_q;
	assign rd_shadow = shadow_q[{two, raddr[3:0]}];
	assign tog       = !rapid_phase_q ? dpsg_pkg::TOGGLE_BYTE : 8'h00;
	assign old_b     = shadow_q[dpsg_pkg::SHADOW_DEPTH-1];
	assign src_b     = shadow_q[dpsg_pkg::SHADOW_DEPTH/2-1];
	assign sel       = old_b & dpsg_pkg::SEL_MASK;
	assign fall      = old_b[0] && !wdata_s1[0];

	always_comb begin
		joy_v = dpsg_pkg::IDLE_BYTE;
		if (!two) begin
			joy_v = pad_s1 | (tog & dpsg_pkg::BTN_MASK);
			if (pad_merge_q == dpsg_pkg::KEY_PAD_ONE) joy_v = joy_v & key_s1;
		end else if (pad_merge_q == dpsg_pkg::KEY_PAD_TWO) begin
			joy_v = key_s1;
		end
		if (rapid_enable_q) joy_v = joy_v | tog;
		joy_m = joy_v & ((joy_v >> 2) | ~dpsg_pkg::BTN_MASK);
		if (swap_buttons_q) begin
			joy_out = (joy_m & dpsg_pkg::BTN_KEEP) | ((joy_m & (dpsg_pkg::BTN_LOW << 1)) >> 1)
				| ((joy_m & dpsg_pkg::BTN_LOW) << 1);
		end else begin
			joy_out = joy_m;
		end
	end

	always_comb begin
		res_d  = '{rdata: dpsg_pkg::IDLE_BYTE, psg_write: 1'b0, psg_chip: dpsg_pkg::CHIP_ONE,
			psg_addr: 4'd0, psg_data: 8'd0, rhythm_trigger: 4'd0};
		sh_we  = 1'b0;
		sh_idx = '0;
		a1_we  = 1'b0;
		a2_we  = 1'b0;
		a3_we  = 1'b0;
		joy_rd = 1'b0;
		if (op_s1 == dpsg_pkg::OP_READ) begin
			if (port_s1 == dpsg_pkg::PORT_DATA_ONE || port_s1 == dpsg_pkg::PORT_DATA_TWO) begin
				if (raddr < dpsg_pkg::REG_JOY || raddr == dpsg_pkg::REG_PORT_B) begin
					res_d.rdata = rd_shadow;
				end else if (raddr == dpsg_pkg::REG_JOY) begin
					res_d.rdata = joy_out;
					joy_rd      = 1'b1;
				end
			end
		end else begin
			unique case (port_s1)
				dpsg_pkg::PORT_ADDR_ONE: a1_we = 1'b1;
				dpsg_pkg::PORT_ADDR_TWO: a2_we = 1'b1;
				dpsg_pkg::PORT_DATA_ONE: begin
					if (addr_one_q < dpsg_pkg::REG_LIMIT) begin
						sh_we           = 1'b1;
						sh_idx          = {1'b0, addr_one_q[3:0]};
						res_d.psg_write = 1'b1;
						res_d.psg_chip  = dpsg_pkg::CHIP_ONE;
						res_d.psg_addr  = addr_one_q[3:0];
						res_d.psg_data  = wdata_s1;
					end
				end
				dpsg_pkg::PORT_DATA_TWO: begin
					if (addr_two_q < dpsg_pkg::REG_JOY) begin
						sh_we           = 1'b1;
						sh_idx          = {1'b1, addr_two_q[3:0]};
						res_d.psg_write = 1'b1;
						res_d.psg_chip  = dpsg_pkg::CHIP_TWO;
						res_d.psg_addr  = addr_two_q[3:0];
						res_d.psg_data  = wdata_s1;
					end else if (addr_two_q == dpsg_pkg::REG_PORT_B) begin
						sh_we  = 1'b1;
						sh_idx = {1'b1, addr_two_q[3:0]};
						if (fall && sel == dpsg_pkg::SEL_LATCH) begin
							a3_we = 1'b1;
						end else if (fall && sel == dpsg_pkg::SEL_WRITE) begin
							if (addr_three_q < dpsg_pkg::REG_JOY) begin
								res_d.psg_write = 1'b1;
								res_d.psg_chip  = dpsg_pkg::CHIP_THREE;
								res_d.psg_addr  = addr_three_q[3:0];
								res_d.psg_data  = src_b;
							end else if (addr_three_q == dpsg_pkg::REG_PORT_B) begin
								res_d.rhythm_trigger = src_b[3:0] & dpsg_pkg::RHYTHM_MASK[3:0];
							end
						end
					end
				end
			endcase
		end
	end

	// state update as the request leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_one_q    <= '0;
			addr_two_q    <= '0;
			addr_three_q  <= '0;
			rapid_phase_q <= 1'b0;
			for (int i = 0; i < dpsg_pkg::SHADOW_DEPTH; i++) shadow_q[i] <= '0;
		end else if (adv) begin
			if (a1_we) addr_one_q <= wdata_s1;
			if (a2_we) addr_two_q <= wdata_s1;
			if (a3_we) addr_three_q <= src_b;
			if (joy_rd) rapid_phase_q <= !rapid_phase_q;
			if (sh_we) shadow_q[sh_idx] <= wdata_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (!out_v_q || out_ready) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_q <= res_d;
	end

	assign out_valid      = out_v_q;
	assign rdata          = res_q.rdata;
	assign psg_write      = res_q.psg_write;
	assign psg_chip       = res_q.psg_chip;
	assign psg_addr       = res_q.psg_addr;
	assign psg_data       = res_q.psg_data;
	assign rhythm_trigger = res_q.rhythm_trigger;

endmodule

`default_nettype wire

### rtl/core/dpsg_checker.sv
// Port-level checker for the dual PSG port decoder, bound to the top level.
// Depends on dpsg_pkg.
`default_nettype none

module dpsg_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] rdata,
	input wire logic       psg_write,
	input wire logic [1:0] psg_chip,
	input wire logic [3:0] psg_addr,
	input wire logic [7:0] psg_data,
	input wire logic [3:0] rhythm_trigger
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rdata) && $stable(psg_data))
		else $error("result changed while stalled");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !psg_write |-> psg_chip == dpsg_pkg::CHIP_ONE && psg_addr == 4'd0
			&& psg_data == 8'd0)
		else $error("write fields set without a PSG write");

	a_chip_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && psg_write |-> psg_chip == dpsg_pkg::CHIP_ONE
			|| psg_chip == dpsg_pkg::CHIP_TWO || psg_chip == dpsg_pkg::CHIP_THREE)
		else $error("PSG write to unknown chip");

	a_rhythm_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rhythm_trigger != 4'd0 |-> !psg_write && rdata == dpsg_pkg::IDLE_BYTE)
		else $error("rhythm trigger together with a write or read");

endmodule

bind dual_psg_port_decoder_with_joystick dpsg_checker u_dpsg_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.rdata          (rdata),
	.psg_write      (psg_write),
	.psg_chip       (psg_chip),
	.psg_addr       (psg_addr),
	.psg_data       (psg_data),
	.rhythm_trigger (rhythm_trigger)
);

`default_nettype wire
